// ===== hdl/ptc_pkg.sv =====
package ptc_pkg;

	// raw conversion width and the bits of it that carry data
	localparam int RAW_W    = 24;
	localparam int ADC_BITS = 24;
	localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NINE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SKIP = 3'd4;

	// register fields
	localparam int COEF_W  = 16;
	localparam int GROUP_W = 64;
	localparam int ALPHA_W = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam int SKIP_W  = 8;
	localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};
	localparam logic [SKIP_W-1:0] SKIP_MIN = SKIP_W'(1);

	// result fields
	localparam int PRESS_W = 32;
	localparam int TEMP_W  = 24;

	// multiply-accumulate unit
	localparam int OP_W   = 25;
	localparam int PROD_W = 2 * OP_W;
	localparam int ACC_W  = 76;
	localparam int LO_W   = 24;

	// intermediate values
	localparam int T24_W  = 37;  // temperature, 24 fractional bits
	localparam int SQ_W   = 46;  // squared temperature
	localparam int CORR_W = 42;  // second-order offset and sensitivity terms
	localparam int OS_W   = 46;  // offset and sensitivity
	localparam int PW_W   = ACC_W - 40;  // pressure before saturation

	// product alignment
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_24 = 2'd1;
	localparam logic [1:0] SH_48 = 2'd2;

	typedef struct packed {
		logic       en;
		logic       clr;
		logic       neg;
		logic       direct;
		logic [1:0] sh;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// unsigned low part as a signed operand
	function automatic logic signed [OP_W-1:0] op_u(input logic [LO_W-1:0] v);
		return $signed({1'b0, v});
	endfunction

	// clamp to the signed pressure range
	function automatic logic signed [PRESS_W-1:0] sat_press(input logic signed [PW_W-1:0] v);
		logic signed [PRESS_W-1:0] r;
		if ((&v[PW_W-1:PRESS_W-1]) || !(|v[PW_W-1:PRESS_W-1])) begin
			r = v[PRESS_W-1:0];
		end else if (v[PW_W-1]) begin
			r = {1'b1, {(PRESS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(PRESS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== hdl/ptc_mac.sv =====
module ptc_mac (
	input  logic                               clk,
	input  ptc_pkg::mac_ctl_t                  ctl,
	input  logic signed [ptc_pkg::OP_W-1:0]    a,
	input  logic signed [ptc_pkg::OP_W-1:0]    b,
	input  logic signed [ptc_pkg::ACC_W-1:0]   dterm,
	output logic signed [ptc_pkg::ACC_W-1:0]   acc_next
);
	import ptc_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	// shared multiplier
	assign prod   = a * b;
	assign prod_x = ACC_W'(prod);

	// align product, pick term, add or subtract
	always_comb begin
		case (ctl.sh)
			SH_24:   shifted = prod_x <<< LO_W;
			SH_48:   shifted = prod_x <<< (2 * LO_W);
			default: shifted = prod_x;
		endcase
		term     = ctl.direct ? dterm : shifted;
		base     = ctl.clr ? '0 : acc_q;
		acc_next = base + (ctl.neg ? ~term : term) + $signed({{(ACC_W-1){1'b0}}, ctl.neg});
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= acc_next;
		end
	end

endmodule

// ===== hdl/ptc_core.sv =====
module ptc_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [ptc_pkg::RAW_W-1:0]            d1,
	input  logic [ptc_pkg::RAW_W-1:0]            d2,
	input  logic                                 pass,
	input  logic [ptc_pkg::GROUP_W-1:0]          coef_low,
	input  logic [ptc_pkg::GROUP_W-1:0]          coef_high,
	input  logic [ptc_pkg::COEF_W-1:0]           coef_nine,
	input  logic [ptc_pkg::ALPHA_W-1:0]          alpha,
	input  logic signed [ptc_pkg::PRESS_W-1:0]   avg,
	input  logic                                 ack,
	output ptc_pkg::core_stat_t                  stat,
	output logic signed [ptc_pkg::PRESS_W-1:0]   pressure,
	output logic signed [ptc_pkg::TEMP_W-1:0]    temperature
);
	import ptc_pkg::*;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
	localparam logic [STEP_W-1:0] ST_TMP_A   = 5'd1;
	localparam logic [STEP_W-1:0] ST_TMP_B   = 5'd2;
	localparam logic [STEP_W-1:0] ST_TMP_C   = 5'd3;
	localparam logic [STEP_W-1:0] ST_SQ_A    = 5'd4;
	localparam logic [STEP_W-1:0] ST_SQ_B    = 5'd5;
	localparam logic [STEP_W-1:0] ST_SQ_C    = 5'd6;
	localparam logic [STEP_W-1:0] ST_SQ_D    = 5'd7;
	localparam logic [STEP_W-1:0] ST_OFF2_A  = 5'd8;
	localparam logic [STEP_W-1:0] ST_OFF2_B  = 5'd9;
	localparam logic [STEP_W-1:0] ST_SENS2_A = 5'd10;
	localparam logic [STEP_W-1:0] ST_SENS2_B = 5'd11;
	localparam logic [STEP_W-1:0] ST_OFF_A   = 5'd12;
	localparam logic [STEP_W-1:0] ST_OFF_B   = 5'd13;
	localparam logic [STEP_W-1:0] ST_OFF_C   = 5'd14;
	localparam logic [STEP_W-1:0] ST_OFF_D   = 5'd15;
	localparam logic [STEP_W-1:0] ST_SENS_A  = 5'd16;
	localparam logic [STEP_W-1:0] ST_SENS_B  = 5'd17;
	localparam logic [STEP_W-1:0] ST_SENS_C  = 5'd18;
	localparam logic [STEP_W-1:0] ST_SENS_D  = 5'd19;
	localparam logic [STEP_W-1:0] ST_P_A     = 5'd20;
	localparam logic [STEP_W-1:0] ST_P_B     = 5'd21;
	localparam logic [STEP_W-1:0] ST_P_C     = 5'd22;
	localparam logic [STEP_W-1:0] ST_SAT     = 5'd23;
	localparam logic [STEP_W-1:0] ST_EMA_A   = 5'd24;
	localparam logic [STEP_W-1:0] ST_EMA_B   = 5'd25;
	localparam logic [STEP_W-1:0] ST_EMA_C   = 5'd26;
	localparam logic [STEP_W-1:0] ST_EMA_D   = 5'd27;
	localparam logic [STEP_W-1:0] ST_DONE    = 5'd28;

	logic [STEP_W-1:0] step_q;

	logic [RAW_W-1:0] d1_q;
	logic [RAW_W-1:0] d2_q;
	logic             pass_q;

	logic signed [T24_W-1:0]   t24_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic [SQ_W-1:0]           sq_q;
	logic [CORR_W-1:0]         off2_q;
	logic [CORR_W-1:0]         sens2_q;
	logic signed [OS_W-1:0]    off_q;
	logic signed [OS_W-1:0]    sens_q;
	logic signed [PW_W-1:0]    pw_q;
	logic signed [PRESS_W-1:0] p_q;
	logic signed [PRESS_W-1:0] res_q;

	logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
	logic [ALPHA_W-1:0] weight_old;

	logic signed [T24_W-LO_W-1:0]   t24_hi;
	logic signed [OS_W-LO_W-1:0]    sens_hi;
	logic signed [PRESS_W-LO_W-1:0] p_hi;
	logic signed [PRESS_W-LO_W-1:0] avg_hi;

	mac_ctl_t                ctl;
	logic signed [OP_W-1:0]  op_a;
	logic signed [OP_W-1:0]  op_b;
	logic signed [ACC_W-1:0] dterm;
	logic signed [ACC_W-1:0] acc_next;

	// coefficient fields
	assign c1 = coef_low[0*COEF_W +: COEF_W];
	assign c2 = coef_low[1*COEF_W +: COEF_W];
	assign c3 = coef_low[2*COEF_W +: COEF_W];
	assign c4 = coef_low[3*COEF_W +: COEF_W];
	assign c5 = coef_high[0*COEF_W +: COEF_W];
	assign c6 = coef_high[1*COEF_W +: COEF_W];
	assign c7 = coef_high[2*COEF_W +: COEF_W];
	assign c8 = coef_high[3*COEF_W +: COEF_W];
	assign c9 = coef_nine;

	assign weight_old = ALPHA_ONE - alpha;

	// signed high digits of split operands
	assign t24_hi  = t24_q[T24_W-1:LO_W];
	assign sens_hi = sens_q[OS_W-1:LO_W];
	assign p_hi    = p_q[PRESS_W-1:LO_W];
	assign avg_hi  = avg[PRESS_W-1:LO_W];

	// operand and operation select per step
	always_comb begin
		ctl   = '0;
		op_a  = '0;
		op_b  = '0;
		dterm = '0;
		case (step_q)
			// temperature with 35 fractional bits
			ST_TMP_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'({c1, 6'b0}));
				op_b = op_u(d2_q);
			end
			ST_TMP_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b1, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(c3));
				op_b = op_u(d1_q);
			end
			ST_TMP_C: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b1, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(c2) << 29;
			end
			// exact square of the temperature
			ST_SQ_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_48};
				op_a = OP_W'(t24_hi);
				op_b = OP_W'(t24_hi);
			end
			ST_SQ_B, ST_SQ_C: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = OP_W'(t24_hi);
				op_b = op_u(t24_q[LO_W-1:0]);
			end
			ST_SQ_D: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(t24_q[LO_W-1:0]);
				op_b = op_u(t24_q[LO_W-1:0]);
			end
			// second-order offset term
			ST_OFF2_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(c4));
				op_b = op_u(LO_W'(sq_q[SQ_W-1:LO_W]));
			end
			ST_OFF2_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(c4));
				op_b = op_u(sq_q[LO_W-1:0]);
			end
			// second-order sensitivity term
			ST_SENS2_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(c5));
				op_b = op_u(LO_W'(sq_q[SQ_W-1:LO_W]));
			end
			ST_SENS2_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(c5));
				op_b = op_u(sq_q[LO_W-1:0]);
			end
			// offset, kept 9 bits finer until the last step
			ST_OFF_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(c7));
				op_b = OP_W'(t24_hi);
			end
			ST_OFF_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(c7));
				op_b = op_u(t24_q[LO_W-1:0]);
			end
			ST_OFF_C: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(c6) << 33;
			end
			ST_OFF_D: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b1, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(off2_q) << 9;
			end
			// sensitivity, same form
			ST_SENS_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(c9));
				op_b = OP_W'(t24_hi);
			end
			ST_SENS_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(c9));
				op_b = op_u(t24_q[LO_W-1:0]);
			end
			ST_SENS_C: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(c8) << 33;
			end
			ST_SENS_D: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b1, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(sens2_q) << 9;
			end
			// pressure: d1 * sens - off * 2^22, then 40 bits down
			ST_P_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(d1_q);
				op_b = OP_W'(sens_hi);
			end
			ST_P_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(d1_q);
				op_b = op_u(sens_q[LO_W-1:0]);
			end
			ST_P_C: begin
				ctl   = '{en: 1'b1, clr: 1'b0, neg: 1'b1, direct: 1'b1, sh: SH_0};
				dterm = ACC_W'(off_q) <<< 22;
			end
			// moving average
			ST_EMA_A: begin
				ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(alpha));
				op_b = OP_W'(p_hi);
			end
			ST_EMA_B: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(alpha));
				op_b = op_u(p_q[LO_W-1:0]);
			end
			ST_EMA_C: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_24};
				op_a = op_u(LO_W'(weight_old));
				op_b = OP_W'(avg_hi);
			end
			ST_EMA_D: begin
				ctl  = '{en: 1'b1, clr: 1'b0, neg: 1'b0, direct: 1'b0, sh: SH_0};
				op_a = op_u(LO_W'(weight_old));
				op_b = op_u(avg[LO_W-1:0]);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	ptc_mac u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.a        (op_a),
		.b        (op_b),
		.dterm    (dterm),
		.acc_next (acc_next)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (start) begin
						step_q <= ST_TMP_A;
					end
				end
				ST_SAT: begin
					step_q <= pass_q ? ST_DONE : ST_EMA_A;
				end
				ST_EMA_D: begin
					step_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack) begin
						step_q <= ST_IDLE;
					end
				end
				default: begin
					// arithmetic steps run in code order
					step_q <= (step_q < ST_DONE) ? step_q + 1'b1 : ST_IDLE;
				end
			endcase
		end
	end

	// operand capture and intermediate results
	always_ff @(posedge clk) begin
		if (step_q == ST_IDLE && start) begin
			d1_q   <= d1;
			d2_q   <= d2;
			pass_q <= pass;
		end
		case (step_q)
			ST_TMP_C: begin
				t24_q  <= acc_next[47:11];
				temp_q <= acc_next[48:25];
			end
			ST_SQ_D:    sq_q    <= acc_next[69:24];
			ST_OFF2_B:  off2_q  <= acc_next[61:20];
			ST_SENS2_B: sens2_q <= acc_next[61:20];
			ST_OFF_D:   off_q   <= acc_next[54:9];
			ST_SENS_D:  sens_q  <= acc_next[54:9];
			ST_P_C:     pw_q    <= acc_next[ACC_W-1:40];
			ST_SAT: begin
				p_q <= sat_press(pw_q);
				if (pass_q) begin
					res_q <= sat_press(pw_q);
				end
			end
			ST_EMA_D:   res_q   <= acc_next[47:16];
			default: begin
			end
		endcase
	end

	assign stat.busy   = (step_q != ST_IDLE);
	assign stat.done   = (step_q == ST_DONE);
	assign pressure    = res_q;
	assign temperature = temp_q;

endmodule

// ===== hdl/pressure_temperature_compensation.sv =====
// channel   direction  handshake                  payload
// sample    in         sample_valid/sample_stall  raw_pressure, raw_temperature, restart
// result    out        result_valid/result_stall  pressure, temperature, temp_taken,
//                                                 temp_needed_next
// config    in         cfg_we                     cfg_index, cfg_data
//
// a result runs through the temperature, square, second-order, offset, sensitivity and
// pressure steps, then saturation and the moving-average steps, which are bypassed when
// alpha is one or for the first sample after reset or restart; the single 25x25
// multiply-accumulate unit takes one step per cycle; the next item is accepted the cycle after the result is loaded
// the result register lets a new item start while a result waits on result_stall
// asynchronous reset clears configuration to its defaults and all filter state
module pressure_temperature_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [23:0]                         raw_pressure,
	input  logic [23:0]                         raw_temperature,
	input  logic                                restart,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [31:0]                  pressure,
	output logic signed [23:0]                  temperature,
	output logic                                temp_taken,
	output logic                                temp_needed_next,
	input  logic                                cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ptc_pkg::*;

	logic [GROUP_W-1:0] coef_low_q;
	logic [GROUP_W-1:0] coef_high_q;
	logic [COEF_W-1:0]  coef_nine_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [SKIP_W-1:0]  temp_skip_q;

	logic signed [PRESS_W-1:0] avg_q;
	logic                      avg_started_q;
	logic [RAW_W-1:0]          cached_q;
	logic                      cache_valid_q;
	logic [SKIP_W-1:0]         skip_cnt_q;
	logic                      taken_q;
	logic                      needed_q;

	logic                      res_valid_q;
	logic signed [PRESS_W-1:0] pressure_q;
	logic signed [TEMP_W-1:0]  temperature_q;
	logic                      temp_taken_q;
	logic                      temp_needed_q;

	logic               accept;
	logic               load;
	logic               valid0;
	logic               started0;
	logic [SKIP_W-1:0]  cnt0;
	logic [SKIP_W-1:0]  cnt1;
	logic [SKIP_W-1:0]  cnt_new;
	logic               take;
	logic               needed;
	logic               pass;
	logic [RAW_W-1:0]   d1_sel;
	logic [RAW_W-1:0]   d2_sel;
	logic [ALPHA_W-1:0] alpha_wr;

	core_stat_t                stat;
	logic signed [PRESS_W-1:0] core_pressure;
	logic signed [TEMP_W-1:0]  core_temperature;

	assign accept = sample_valid && !sample_stall;
	assign load   = stat.done && (!res_valid_q || !result_stall);

	// temperature reuse decision for the item at the port
	always_comb begin
		valid0   = cache_valid_q && !restart;
		started0 = avg_started_q && !restart;
		cnt0     = restart ? '0 : skip_cnt_q;
		cnt1     = (cnt0 == SKIP_MAX) ? cnt0 : cnt0 + 1'b1;
		take     = !valid0 || (cnt1 >= temp_skip_q);
		cnt_new  = take ? '0 : cnt1;
		needed   = (({1'b0, cnt_new} + 1'b1) >= {1'b0, temp_skip_q});
		d1_sel   = raw_pressure & RAW_MASK;
		d2_sel   = take ? (raw_temperature & RAW_MASK) : cached_q;
		pass     = (alpha_q == ALPHA_ONE) || !started0;
	end

	// ema weight write saturates at one
	assign alpha_wr = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[ALPHA_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_low_q  <= '0;
			coef_high_q <= '0;
			coef_nine_q <= '0;
			alpha_q     <= ALPHA_ONE;
			temp_skip_q <= SKIP_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_LOW:  coef_low_q  <= cfg_data[GROUP_W-1:0];
				REG_COEF_HIGH: coef_high_q <= cfg_data[GROUP_W-1:0];
				REG_COEF_NINE: coef_nine_q <= cfg_data[COEF_W-1:0];
				REG_EMA_ALPHA: alpha_q     <= alpha_wr;
				REG_TEMP_SKIP: begin
					temp_skip_q <= (cfg_data[SKIP_W-1:0] == '0) ? SKIP_MIN : cfg_data[SKIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// temperature cache and skip count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_q      <= '0;
			cache_valid_q <= 1'b0;
			skip_cnt_q    <= '0;
			taken_q       <= 1'b0;
			needed_q      <= 1'b0;
		end else begin
			if (accept) begin
				skip_cnt_q <= cnt_new;
				taken_q    <= take;
				needed_q   <= needed;
				if (take) begin
					cached_q      <= d2_sel;
					cache_valid_q <= 1'b1;
				end else begin
					cache_valid_q <= valid0;
				end
			end
			if (cfg_we && cfg_index == REG_TEMP_SKIP) begin
				skip_cnt_q <= '0;
			end
		end
	end

	// moving average state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q         <= '0;
			avg_started_q <= 1'b0;
		end else if (load) begin
			avg_q         <= core_pressure;
			avg_started_q <= 1'b1;
		end else if (accept && restart) begin
			avg_q         <= '0;
			avg_started_q <= 1'b0;
		end
	end

	ptc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.d1          (d1_sel),
		.d2          (d2_sel),
		.pass        (pass),
		.coef_low    (coef_low_q),
		.coef_high   (coef_high_q),
		.coef_nine   (coef_nine_q),
		.alpha       (alpha_q),
		.avg         (avg_q),
		.ack         (load),
		.stat        (stat),
		.pressure    (core_pressure),
		.temperature (core_temperature)
	);

	assign sample_stall = stat.busy;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pressure_q    <= core_pressure;
			temperature_q <= core_temperature;
			temp_taken_q  <= taken_q;
			temp_needed_q <= needed_q;
		end
	end

	assign result_valid     = res_valid_q;
	assign pressure         = pressure_q;
	assign temperature      = temperature_q;
	assign temp_taken       = temp_taken_q;
	assign temp_needed_next = temp_needed_q;

endmodule
